// ===== rtl/hufd_pkg.sv =====
// Shared types and constants for the Huffman tree decoder.
// Holds the beat payload structs, the queue command codes and the back end states.
package hufd_pkg;

  // Fixed field widths of the beats.
  localparam int BYTE_BITS   = 8;
  localparam int IN_IDX_W    = 9;
  localparam int PAD_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  // Decoupling queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_BITS  = 1'b1;

  // Input item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Input beat.
  typedef struct packed {
    logic                 kind;
    logic [IN_IDX_W-1:0]  node_addr;
    logic                 node_is_leaf;
    logic [7:0]           node_symbol;
    logic [IN_IDX_W-1:0]  left_child;
    logic [IN_IDX_W-1:0]  right_child;
    logic [7:0]           code_byte;
    logic                 is_final_byte;
  } in_t;

  // Output beat.
  typedef struct packed {
    logic [7:0] symbol;
    logic       last_of_run;
  } out_t;

  // Commands carried by the queue.
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_DATA,
    CMD_ROOT
  } cmd_t;

  // Back end states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT_RD,
    ST_WALK
  } bst_t;

endpackage

// ===== rtl/hufd_front.sv =====
// Front end of the Huffman tree decoder: accepts input and configuration beats,
// wraps table indexes modulo the table size and queues commands for the back end.
// Depends on hufd_pkg.
module hufd_front #(
  parameter int NODE_COUNT = 512
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  hufd_pkg::in_t                      in_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hufd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hufd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [hufd_pkg::PAD_W-1:0]         pad_bits,
  output logic                               q_valid,
  input  logic                               q_pop,
  output logic [3*$clog2(NODE_COUNT)+20-1:0] q_data
);
  import hufd_pkg::*;

  localparam int IW    = $clog2(NODE_COUNT);
  localparam int SHIFT = IN_IDX_W + IW;
  localparam int RW    = SHIFT;
  localparam int PW    = IN_IDX_W + RW;
  localparam int DW    = IN_IDX_W + IW + 1;
  localparam logic [RW-1:0] RECIP = RW'((2 ** SHIFT) / NODE_COUNT);

  typedef struct packed {
    logic          leaf;
    logic [7:0]    sym;
    logic [IW-1:0] left;
    logic [IW-1:0] right;
  } node_t;

  typedef struct packed {
    cmd_t          cmd;
    logic [IW-1:0] addr;
    node_t         node;
    logic [7:0]    code;
    logic          fin;
  } qent_t;

  // Quotient estimate by reciprocal multiplication; it is exact or one too small.
  function automatic logic [IN_IDX_W-1:0] quot_est(input logic [IN_IDX_W-1:0] v);
    logic [PW-1:0] prod;
    prod = PW'(v) * PW'(RECIP);
    return IN_IDX_W'(prod >> SHIFT);
  endfunction

  // Remainder from the estimate, with a single correcting subtract.
  function automatic logic [IW-1:0] wrap_rem(input logic [IN_IDX_W-1:0] v,
                                             input logic [IN_IDX_W-1:0] q);
    logic [DW-1:0] diff;
    diff = DW'(v) - DW'(q) * DW'(NODE_COUNT);
    if (diff >= DW'(NODE_COUNT)) begin
      diff = diff - DW'(NODE_COUNT);
    end
    return IW'(diff);
  endfunction

  // Stage one registers.
  logic                s1_valid;
  cmd_t                s1_cmd;
  logic [IN_IDX_W-1:0] s1_a;
  logic [IN_IDX_W-1:0] s1_l;
  logic [IN_IDX_W-1:0] s1_r;
  logic [IN_IDX_W-1:0] s1_qa;
  logic [IN_IDX_W-1:0] s1_ql;
  logic [IN_IDX_W-1:0] s1_qr;
  logic                s1_leaf;
  logic [7:0]          s1_sym;
  logic [7:0]          s1_code;
  logic                s1_fin;

  // Queue storage.
  qent_t               fifo [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  logic                space;
  logic                in_take;
  logic                cfg_take;
  logic                root_take;
  logic [IN_IDX_W-1:0] a_raw;
  qent_t               wr_ent;

  // Room for one more beat counts the beat still in stage one.
  always_comb begin
    space     = (count + QCNT_W'(s1_valid)) < QCNT_W'(QUEUE_DEPTH);
    cfg_ready = space;
    in_ready  = space && !cfg_valid;
    in_take   = in_valid && in_ready;
    cfg_take  = cfg_valid && cfg_ready;
    root_take = cfg_take && (cfg_index == CFG_ROOT_NODE);
    a_raw     = root_take ? IN_IDX_W'(cfg_data) : in_data.node_addr;
  end

  // Classify the beat and start the index wrap.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pad_bits <= '0;
    end else begin
      s1_valid <= in_take || root_take;
      if (cfg_take) begin
        case (cfg_index)
          CFG_PAD_BITS: pad_bits <= PAD_W'(cfg_data);
          default: ;
        endcase
      end
    end
    if (in_take || root_take) begin
      if (root_take) begin
        s1_cmd <= CMD_ROOT;
      end else if (in_data.kind == KIND_DATA) begin
        s1_cmd <= CMD_DATA;
      end else begin
        s1_cmd <= CMD_LOAD;
      end
      s1_a    <= a_raw;
      s1_l    <= in_data.left_child;
      s1_r    <= in_data.right_child;
      s1_qa   <= quot_est(a_raw);
      s1_ql   <= quot_est(in_data.left_child);
      s1_qr   <= quot_est(in_data.right_child);
      s1_leaf <= in_data.node_is_leaf;
      s1_sym  <= in_data.node_symbol;
      s1_code <= in_data.code_byte;
      s1_fin  <= in_data.is_final_byte;
    end
  end

  // Finish the wrap and form the queue entry.
  always_comb begin
    wr_ent.cmd        = s1_cmd;
    wr_ent.addr       = wrap_rem(s1_a, s1_qa);
    wr_ent.node.leaf  = s1_leaf;
    wr_ent.node.sym   = s1_sym;
    wr_ent.node.left  = wrap_rem(s1_l, s1_ql);
    wr_ent.node.right = wrap_rem(s1_r, s1_qr);
    wr_ent.code       = s1_code;
    wr_ent.fin        = s1_fin;
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(s1_valid) - QCNT_W'(q_pop);
    end
    if (s1_valid) begin
      fifo[wr_ptr] <= wr_ent;
    end
  end

  assign q_valid = (count != '0);
  assign q_data  = fifo[rd_ptr];

endmodule

// ===== rtl/hufd_back.sv =====
// Back end of the Huffman tree decoder: node table memory, tree walk and output stage.
// Takes commands from the front end queue. Depends on hufd_pkg.
module hufd_back #(
  parameter int NODE_COUNT = 512
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  output logic                               q_pop,
  input  logic [3*$clog2(NODE_COUNT)+20-1:0] q_data,
  input  logic [hufd_pkg::PAD_W-1:0]         pad_bits,
  output logic                               out_valid,
  input  logic                               out_ready,
  output hufd_pkg::out_t                     out_data
);
  import hufd_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);

  typedef struct packed {
    logic          leaf;
    logic [7:0]    sym;
    logic [IW-1:0] left;
    logic [IW-1:0] right;
  } node_t;

  typedef struct packed {
    cmd_t          cmd;
    logic [IW-1:0] addr;
    node_t         node;
    logic [7:0]    code;
    logic          fin;
  } qent_t;

  bst_t           state;
  bst_t           state_next;

  // Node table with registered read data.
  node_t          mem [NODE_COUNT];
  node_t          mem_q;

  logic [IW-1:0]  root_idx;
  node_t          root_ent;
  node_t          cur_ent;
  logic [7:0]     byte_sh;
  logic [PAD_W-1:0] bits_left;
  logic           have_q;
  logic           fin;
  logic           pend_valid;
  logic [7:0]     pend_sym;

  qent_t          qe;
  node_t          eff;
  logic           step;
  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  logic           wr_en;
  logic           emit;
  logic           finish;
  logic           push;
  logic [PAD_W-1:0] used_bits;

  // Node the walk stands on, taking a just read leaf as a return to the root.
  always_comb begin
    qe   = qent_t'(q_data);
    step = !out_valid || out_ready;
    if (have_q) begin
      eff = mem_q.leaf ? root_ent : mem_q;
    end else begin
      eff = cur_ent;
    end
    if (!qe.fin) begin
      used_bits = PAD_W'(BYTE_BITS);
    end else if (pad_bits > PAD_W'(BYTE_BITS)) begin
      used_bits = '0;
    end else begin
      used_bits = PAD_W'(BYTE_BITS) - pad_bits;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (qe.cmd)
            CMD_DATA: state_next = ST_WALK;
            CMD_ROOT: state_next = ST_ROOT_RD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ROOT_RD: state_next = ST_IDLE;
      ST_WALK: begin
        if (step && (bits_left == '0) && !have_q) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs: queue pop, table access and output pushes.
  always_comb begin
    q_pop   = 1'b0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = qe.addr;
    emit    = 1'b0;
    finish  = 1'b0;
    case (state)
      ST_IDLE: begin
        q_pop = q_valid;
        wr_en = q_valid && (qe.cmd == CMD_LOAD);
        rd_en = q_valid && (qe.cmd == CMD_ROOT);
      end
      ST_WALK: begin
        emit   = step && have_q && mem_q.leaf;
        finish = step && (bits_left == '0) && !have_q;
        if (step && (bits_left != '0) && !eff.leaf) begin
          rd_en   = 1'b1;
          rd_addr = byte_sh[BYTE_BITS-1] ? eff.right : eff.left;
        end
      end
      default: ;
    endcase
    push = (emit || finish) && pend_valid;
  end

  // Node table port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[qe.addr] <= qe.node;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Walk registers and output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      root_idx   <= '0;
      have_q     <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (qe.cmd)
              CMD_LOAD: begin
                if (qe.addr == root_idx) begin
                  root_ent <= qe.node;
                  cur_ent  <= qe.node;
                end else begin
                  cur_ent <= root_ent;
                end
              end
              CMD_ROOT: root_idx <= qe.addr;
              CMD_DATA: begin
                byte_sh   <= qe.code;
                bits_left <= used_bits;
                fin       <= qe.fin;
                have_q    <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_ROOT_RD: begin
          root_ent <= mem_q;
          cur_ent  <= mem_q;
        end
        ST_WALK: begin
          if (step) begin
            if (bits_left != '0) begin
              byte_sh   <= byte_sh << 1;
              bits_left <= bits_left - 1'b1;
              cur_ent   <= eff;
              have_q    <= !eff.leaf;
            end else if (have_q) begin
              cur_ent <= eff;
              have_q  <= 1'b0;
            end else if (fin) begin
              cur_ent <= root_ent;
            end
            if (emit) begin
              pend_valid <= 1'b1;
              pend_sym   <= mem_q.sym;
            end else if (finish) begin
              pend_valid <= 1'b0;
            end
          end
        end
        default: ;
      endcase
      // A pushed symbol is the last of its run only when the byte closes.
      if (push) begin
        out_valid            <= 1'b1;
        out_data.symbol      <= pend_sym;
        out_data.last_of_run <= finish;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/huffman_tree_decoder.sv =====
// Top level of the Huffman tree decoder: front end, command queue and back end.
// Depends on hufd_pkg, hufd_front and hufd_back.
//
// Load beats write one node of the code tree; data beats carry one compressed
// byte, walked most significant bit first, giving one output beat per decoded
// symbol with last_of_run set on the final symbol of that byte. The back end
// reads the node table through a single port with registered read data, one
// read per consumed bit. A data byte occupies it to take the command, for
// each used bit, to settle the last read when it still has to be settled,
// and to close the run, and longer while the output is stalled. A load is
// taken in the idle state alone, and a root_node write passes through the
// idle and root read states. The front end registers each beat in stage one
// and then in a four entry queue, so input beats keep flowing while the walk
// runs and the queue has room. The node table is not cleared by reset: every
// node the walk can reach must be loaded first.
module huffman_tree_decoder #(
  parameter int NODE_COUNT = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hufd_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hufd_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hufd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hufd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hufd_pkg::*;

  localparam int QW = 3 * $clog2(NODE_COUNT) + 20;

  logic             q_valid;
  logic             q_pop;
  logic [QW-1:0]    q_data;
  logic [PAD_W-1:0] pad_bits;

  // Accept, classify and queue.
  hufd_front #(
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pad_bits  (pad_bits),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data)
  );

  // Table, walk and output stage.
  hufd_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .pad_bits  (pad_bits),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/hufd_checker.sv =====
// Port level checks for the Huffman tree decoder, bound to the top level.
// Depends on hufd_pkg and huffman_tree_decoder.
module hufd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input hufd_pkg::out_t                  out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);
  import hufd_pkg::*;

  // A stalled output beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat dropped or changed while stalled");

  // Reset empties the output stage.
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A pending configuration write holds off input beats.
  a_cfg_first: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> !in_ready)
    else $error("input accepted alongside a configuration write");

  // Both channels see the same queue space when no write is pending.
  a_same_space: assert property (@(posedge clk) disable iff (rst)
    !cfg_valid |-> (cfg_ready == in_ready))
    else $error("input and configuration ready disagree");

endmodule

bind huffman_tree_decoder hufd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
